>>> sv/lightmap_texel_clamp_pack_assert.svh
// Assertion macros for the lightmap texel clamp and pack block.
// Included by the top-level RTL file, which checks its own logic; no dependencies.
`ifndef LIGHTMAP_TEXEL_CLAMP_PACK_ASSERT_SVH
`define LIGHTMAP_TEXEL_CLAMP_PACK_ASSERT_SVH
`ifndef SYNTHESIS
`define LTCP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ltcp: assertion failed");
`define LTCP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ltcp: implication failed");
`else
`define LTCP_ASSERT(lbl, clk, rst, prop)
`define LTCP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/ltcp_pkg.sv
// Shared constants, types and codes for the lightmap texel clamp and pack block.
// No dependencies.
package ltcp_pkg;

  localparam int LIGHT_W         = 21;
  localparam int LIGHT_FRAC_BITS = 4;
  localparam int STAIN_W         = 8;
  localparam int GAIN_W          = 12;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int LIMIT_W         = STAIN_W + GAIN_W;
  localparam int CMP_W           = LIGHT_W + GAIN_FRAC_BITS;
  localparam int CH_W            = LIGHT_W - 1 - LIGHT_FRAC_BITS;
  localparam int Q_W             = 8;
  localparam int NUM_W           = CH_W + Q_W;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES      = Q_W / DIV_BITS_PER_STAGE;
  localparam int DIV_FIRST       = 4;
  localparam int PIPE_STAGES     = 3 + DIV_STAGES + 3;
  localparam int SUM_W           = 10;
  localparam int THIRD_W         = 20;
  localparam int THIRD_MULT      = 683;
  localparam int THIRD_SHIFT     = 11;
  localparam int PROD_W          = 16;

  localparam int IN_TDATA_W      = 88;
  localparam int STAIN_OFS       = 3 * LIGHT_W;
  localparam int OUT_TDATA_W     = 32;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
  localparam logic [Q_W-1:0]    ALPHA_FULL = 8'hFF;

  typedef logic [CH_W-1:0]  ch_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef enum logic [1:0] {
    REG_GAIN     = 2'd0,
    REG_MONO     = 2'd1,
    REG_STAIN_EN = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MONO_NORMAL     = 2'd0,
    MONO_LUMA_RED   = 2'd1,
    MONO_FAKED      = 2'd2,
    MONO_ALPHA_ONLY = 2'd3
  } mono_t;

  typedef struct packed {
    logic           big;
    logic [Q_W-1:0] alpha;
    logic [Q_W-1:0] low_r;
    logic [Q_W-1:0] low_g;
    logic [Q_W-1:0] low_b;
  } side_t;

endpackage

>>> sv/lightmap_texel_clamp_pack.sv
// Lightmap texel clamp and pack: top level with APB registers and pipeline.
// Depends on ltcp_pkg, ltcp_div and lightmap_texel_clamp_pack_assert.svh.
//
//  channel | dir | handshake                   | content
//  --------+-----+-----------------------------+-------------------------------
//  s_*     | in  | s_tvalid / s_tready         | light RGB, stain RGB, present
//  m_*     | out | m_tvalid / m_tready         | packed RGBA bytes
//  apb     | in  | psel, penable, pwrite       | gain, mono mode, stain enable
//
// One texel per cycle sustained unless m_tready stalls. Stages: limit multiply,
// clamp, max, four divider stages (two quotient bits each), rescale select
// with the divide-by-3, faked-colour multiply, divide-by-255 into the output
// register. Reset clears the valid bits and the registers to their defaults.
// A stall backs up stage by stage; empty stages keep taking new requests.
`include "lightmap_texel_clamp_pack_assert.svh"
module lightmap_texel_clamp_pack import ltcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [20:0] light_red, [41:21] light_green, [62:42] light_blue,
  // [70:63] stain_red, [78:71] stain_green, [86:79] stain_blue, [87] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] stain_present
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  function automatic logic [Q_W-1:0] div255(logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:Q_W]);
    return s[Q_W +: Q_W];
  endfunction

  // ---------------- configuration registers ----------------
  logic [GAIN_W-1:0] gain_q;
  mono_t             mono_q;
  logic              stain_en_q;
  reg_idx_t          reg_idx;
  logic              cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q     <= GAIN_RESET;
      mono_q     <= MONO_NORMAL;
      stain_en_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_GAIN:     gain_q     <= pwdata[GAIN_W-1:0];
        REG_MONO:     mono_q     <= mono_t'(pwdata[1:0]);
        REG_STAIN_EN: stain_en_q <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:     prdata = APB_DATA_W'(gain_q);
      REG_MONO:     prdata = APB_DATA_W'(mono_q);
      REG_STAIN_EN: prdata = APB_DATA_W'(stain_en_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [PIPE_STAGES:1]   vld;
  logic [PIPE_STAGES:1]   vin;
  logic [PIPE_STAGES+1:1] en;

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    en[PIPE_STAGES+1] = m_tready;
    for (int k = PIPE_STAGES; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vin = {vld[PIPE_STAGES-1:1], s_tvalid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en[PIPE_STAGES:1] & vin) | (~en[PIPE_STAGES:1] & vld);
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[PIPE_STAGES];

  // ---------------- stage 1: stain limit ----------------
  logic signed [LIGHT_W-1:0] light_in [3];
  logic [STAIN_W-1:0]        stain_in [3];
  logic signed [LIGHT_W-1:0] light1   [3];
  logic [LIMIT_W-1:0]        lim1     [3];
  logic                      use1;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      light_in[j] = s_tdata[j*LIGHT_W +: LIGHT_W];
      stain_in[j] = s_tdata[STAIN_OFS + j*STAIN_W +: STAIN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        light1[j] <= light_in[j];
        lim1[j]   <= LIMIT_W'(stain_in[j]) * LIMIT_W'(gain_q);
      end
      use1 <= stain_en_q & s_tuser;
    end
  end

  // ---------------- stage 2: clamp and truncate ----------------
  ch_t ch2_nx [3];
  ch_t ch2    [3];

  always_comb begin
    logic signed [CMP_W-1:0] lsh;
    logic signed [CMP_W-1:0] lim_s;
    logic                    over;
    for (int j = 0; j < 3; j++) begin
      lsh   = CMP_W'(light1[j]) <<< (GAIN_FRAC_BITS - LIGHT_FRAC_BITS);
      lim_s = signed'(CMP_W'(lim1[j]));
      over  = use1 && (lsh > lim_s);
      if (over) begin
        ch2_nx[j] = CH_W'(lim1[j][LIMIT_W-1:GAIN_FRAC_BITS]);
      end else if (light1[j][LIGHT_W-1]) begin
        ch2_nx[j] = '0;
      end else begin
        ch2_nx[j] = light1[j][LIGHT_W-2:LIGHT_FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ch2 <= ch2_nx;
    end
  end

  // ---------------- stage 3: brightest channel ----------------
  ch_t   mx_rg;
  ch_t   mx;
  num_t  num3 [3];
  ch_t   mx3;
  side_t side3_nx;
  side_t side3;

  always_comb begin
    mx_rg = (ch2[0] > ch2[1]) ? ch2[0] : ch2[1];
    mx    = (ch2[2] > mx_rg) ? ch2[2] : mx_rg;
    side3_nx.big   = |mx[CH_W-1:Q_W];
    side3_nx.alpha = side3_nx.big ? ALPHA_FULL : mx[Q_W-1:0];
    side3_nx.low_r = ch2[0][Q_W-1:0];
    side3_nx.low_g = ch2[1][Q_W-1:0];
    side3_nx.low_b = ch2[2][Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        num3[j] <= (num_t'(ch2[j]) << Q_W) - num_t'(ch2[j]);
      end
      mx3   <= mx;
      side3 <= side3_nx;
    end
  end

  // ---------------- stages 4..7: rescale divide ----------------
  logic [Q_W-1:0] quo [3];
  side_t          side_q [DIV_STAGES];

  ltcp_div u_div (
    .clk (clk),
    .en  (en[DIV_FIRST +: DIV_STAGES]),
    .num (num3),
    .den (mx3),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[DIV_FIRST + k]) begin
        side_q[k] <= (k == 0) ? side3 : side_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // ---------------- stage 8: select and mode ----------------
  side_t             side7;
  logic [Q_W-1:0]    c7   [3];
  logic [SUM_W-1:0]  sum7;
  logic [THIRD_W-1:0] third_prod;
  logic [Q_W-1:0]    c8_nx [3];
  logic [Q_W-1:0]    a8_nx;
  logic [Q_W-1:0]    c8   [3];
  logic [Q_W-1:0]    a8;

  assign side7 = side_q[DIV_STAGES-1];

  always_comb begin
    c7[0] = side7.big ? quo[0] : side7.low_r;
    c7[1] = side7.big ? quo[1] : side7.low_g;
    c7[2] = side7.big ? quo[2] : side7.low_b;
    sum7  = SUM_W'(c7[0]) + SUM_W'(c7[1]) + SUM_W'(c7[2]);
    // floor(sum / 3) by reciprocal; exact for sums up to 765
    third_prod = THIRD_W'(sum7) * THIRD_W'(THIRD_MULT);
    unique case (mono_q)
      MONO_NORMAL: begin
        c8_nx = c7;
        a8_nx = side7.alpha;
      end
      MONO_LUMA_RED: begin
        c8_nx[0] = side7.alpha;
        c8_nx[1] = '0;
        c8_nx[2] = '0;
        a8_nx    = side7.alpha;
      end
      MONO_FAKED: begin
        c8_nx = c7;
        a8_nx = ALPHA_FULL - third_prod[THIRD_SHIFT +: Q_W];
      end
      MONO_ALPHA_ONLY: begin
        c8_nx[0] = '0;
        c8_nx[1] = '0;
        c8_nx[2] = '0;
        a8_nx    = ALPHA_FULL - side7.alpha;
      end
      default: begin
        c8_nx = c7;
        a8_nx = side7.alpha;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[DIV_FIRST + DIV_STAGES]) begin
      c8 <= c8_nx;
      a8 <= a8_nx;
    end
  end

  // ---------------- stage 9: faked-colour multiply ----------------
  logic [PROD_W-1:0] p9 [3];
  logic [Q_W-1:0]    c9 [3];
  logic [Q_W-1:0]    a9;

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES-1]) begin
      for (int j = 0; j < 3; j++) begin
        p9[j] <= PROD_W'(c8[j]) * PROD_W'(a8);
      end
      c9 <= c8;
      a9 <= a8;
    end
  end

  // ---------------- stage 10: output register ----------------
  logic [Q_W-1:0] out_c [3];
  logic [Q_W-1:0] out_a;

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES]) begin
      for (int j = 0; j < 3; j++) begin
        out_c[j] <= (mono_q == MONO_FAKED) ? div255(p9[j]) : c9[j];
      end
      out_a <= a9;
    end
  end

  assign m_tdata = {out_a, out_c[2], out_c[1], out_c[0]};

  // ---------------- checks ----------------
  `LTCP_ASSERT_IMPL(a_normal_alpha_max, clk, rst, m_tvalid && mono_q == MONO_NORMAL, (out_c[0] <= out_a) && (out_c[1] <= out_a) && (out_c[2] <= out_a))
  `LTCP_ASSERT_IMPL(a_alpha_only_dark, clk, rst, m_tvalid && mono_q == MONO_ALPHA_ONLY, (out_c[0] == '0) && (out_c[1] == '0) && (out_c[2] == '0))
  `LTCP_ASSERT_IMPL(a_luma_in_red, clk, rst, m_tvalid && mono_q == MONO_LUMA_RED, (out_c[0] == out_a) && (out_c[1] == '0) && (out_c[2] == '0))
  `LTCP_ASSERT_IMPL(a_full_pipe_blocks, clk, rst, (&vld) && !m_tready, !s_tready)

endmodule

>>> sv/ltcp_div.sv
// Pipelined restoring divider, three lanes sharing one divisor: q = num / den.
// Two quotient bits per stage, MSB first. Depends on ltcp_pkg.
module ltcp_div import ltcp_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  num_t                  num [3],
  input  ch_t                   den,
  output logic [Q_W-1:0]        quo [3]
);

  typedef struct packed {
    num_t           rem;
    logic [Q_W-1:0] q;
  } div_t;

  function automatic div_t div_step(div_t s, ch_t d, int stage);
    div_t r;
    num_t t;
    logic ge;
    r = s;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      t  = num_t'(d) << (Q_W - 1 - stage * DIV_BITS_PER_STAGE - j);
      ge = (r.rem >= t);
      if (ge) begin
        r.rem = r.rem - t;
      end
      r.q = {r.q[Q_W-2:0], ge};
    end
    return r;
  endfunction

  ch_t  den_src [DIV_STAGES];
  ch_t  den_q   [DIV_STAGES];
  div_t src     [DIV_STAGES][3];
  div_t nxt     [DIV_STAGES][3];
  div_t st_q    [DIV_STAGES][3];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign den_src[k] = den;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign src[k][j] = '{rem: num[j], q: '0};
      end
    end else begin : g_body
      assign den_src[k] = den_q[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign src[k][j] = st_q[k-1][j];
      end
    end
    for (genvar j = 0; j < 3; j++) begin : g_step
      assign nxt[k][j] = div_step(src[k][j], den_src[k], k);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        den_q[k] <= den_src[k];
        for (int j = 0; j < 3; j++) begin
          st_q[k][j] <= nxt[k][j];
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_out
    assign quo[j] = st_q[DIV_STAGES-1][j].q;
  end

endmodule
